// File: hdl/callsign28_unpack_unit_assert.svh
// callsign28_unpack_unit_assert.svh: assertion macros shared by the callsign unpack RTL.
// Expects clk_i and rst_ni in the scope of every module that uses the macros.
// Depends on nothing else.
`ifndef CALLSIGN28_UNPACK_UNIT_ASSERT_SVH
`define CALLSIGN28_UNPACK_UNIT_ASSERT_SVH
`ifndef SYNTH
// property must hold on every clock edge out of reset
`define CU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be true on a clock edge out of reset
`define CU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CU_ASSERT(lbl, prop, msg)
`define CU_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/cs28u_pkg.sv
// cs28u_pkg: types, constants and decode functions for the callsign unpack unit.
// Used by the interfaces, front, queue, back and top level. No dependencies.
package cs28u_pkg;

  localparam int unsigned CallW        = 28;
  localparam int unsigned CharW        = 7;
  localparam int unsigned LenW         = 4;
  localparam int unsigned NameMaxLen   = 10;
  localparam int unsigned SidxW        = 6;
  localparam int unsigned SymW         = 6;
  localparam int unsigned SpecialBase  = 262177560;
  localparam int unsigned SpecialCount = 54;
  localparam int unsigned QueueDepthDef = 2;

  // quotient widths after each radix step (max input 2^28-1)
  localparam int unsigned Q1W = 24;  // /27
  localparam int unsigned Q2W = 19;  // /27
  localparam int unsigned Q3W = 14;  // /27
  localparam int unsigned Q4W = 11;  // /10

  // reciprocal constants, exact for every 28-bit dividend
  localparam int unsigned RecipW = 29;
  localparam int unsigned ProdW  = CallW + RecipW;
  localparam logic [RecipW-1:0] Recip27 = 29'd318145726;
  localparam logic [RecipW-1:0] Recip10 = 29'd429496730;
  localparam logic [RecipW-1:0] Recip36 = 29'd477218589;
  localparam int unsigned Shift27 = 33;
  localparam int unsigned Shift10 = 32;
  localparam int unsigned Shift36 = 34;

  typedef logic [CharW-1:0] char_t;

  // ASCII codes used by the rewrite and suffix rules
  localparam char_t ChSpace = 7'h20;
  localparam char_t ChSlash = 7'h2F;
  localparam char_t ChAt    = 7'h40;
  localparam char_t Ch0     = 7'h30;
  localparam char_t Ch3     = 7'h33;
  localparam char_t ChA     = 7'h41;
  localparam char_t ChD     = 7'h44;
  localparam char_t ChP     = 7'h50;
  localparam char_t ChQ     = 7'h51;
  localparam char_t ChX     = 7'h58;
  localparam char_t ChZ     = 7'h5A;

  // one decoded callsign: length 2..10, first character in chars[0]
  typedef struct packed {
    logic [LenW-1:0]               len;
    char_t [NameMaxLen-1:0]        chars;
  } text_t;

  // quotient by reciprocal multiply
  function automatic logic [CallW-1:0] div27(input logic [CallW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(Recip27);
    return CallW'(prod >> Shift27);
  endfunction

  function automatic logic [CallW-1:0] div10(input logic [CallW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(Recip10);
    return CallW'(prod >> Shift10);
  endfunction

  function automatic logic [CallW-1:0] div36(input logic [CallW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(Recip36);
    return CallW'(prod >> Shift36);
  endfunction

  // symbol index to ASCII: 0-9, A-Z, space, slash, at
  function automatic char_t sym_char(input logic [SymW-1:0] idx);
    char_t c;
    if (idx < 6'd10) begin
      c = Ch0 + CharW'(idx);
    end else if (idx < 6'd36) begin
      c = ChA + CharW'(idx - 6'd10);
    end else if (idx == 6'd36) begin
      c = ChSpace;
    end else if (idx == 6'd37) begin
      c = ChSlash;
    end else begin
      c = ChAt;
    end
    return c;
  endfunction

  // special group names, right-justified in 80 bits
  function automatic logic [8*NameMaxLen-1:0] name_raw(input logic [SidxW-1:0] idx);
    logic [8*NameMaxLen-1:0] r;
    case (idx)
      6'd0:  r = 80'("<....>");
      6'd1:  r = 80'("@ALLCALL");
      6'd2:  r = 80'({"@J", "S8NET"});
      6'd3:  r = 80'("@DX/NA");
      6'd4:  r = 80'("@DX/SA");
      6'd5:  r = 80'("@DX/EU");
      6'd6:  r = 80'("@DX/AS");
      6'd7:  r = 80'("@DX/AF");
      6'd8:  r = 80'("@DX/OC");
      6'd9:  r = 80'("@DX/AN");
      6'd10: r = 80'("@REGION/1");
      6'd11: r = 80'("@REGION/2");
      6'd12: r = 80'("@REGION/3");
      6'd13: r = 80'("@GROUP/0");
      6'd14: r = 80'("@GROUP/1");
      6'd15: r = 80'("@GROUP/2");
      6'd16: r = 80'("@GROUP/3");
      6'd17: r = 80'("@GROUP/4");
      6'd18: r = 80'("@GROUP/5");
      6'd19: r = 80'("@GROUP/6");
      6'd20: r = 80'("@GROUP/7");
      6'd21: r = 80'("@GROUP/8");
      6'd22: r = 80'("@GROUP/9");
      6'd23: r = 80'("@COMMAND");
      6'd24: r = 80'("@CONTROL");
      6'd25: r = 80'("@NET");
      6'd26: r = 80'("@NTS");
      6'd27: r = 80'("@RESERVE/0");
      6'd28: r = 80'("@RESERVE/1");
      6'd29: r = 80'("@RESERVE/2");
      6'd30: r = 80'("@RESERVE/3");
      6'd31: r = 80'("@RESERVE/4");
      6'd32: r = 80'("@APRSIS");
      6'd33: r = 80'("@RAGCHEW");
      6'd34: r = 80'({"@J", "S8"});
      6'd35: r = 80'("@EMCOMM");
      6'd36: r = 80'("@ARES");
      6'd37: r = 80'("@MARS");
      6'd38: r = 80'("@AMRRON");
      6'd39: r = 80'("@RACES");
      6'd40: r = 80'("@RAYNET");
      6'd41: r = 80'("@RADAR");
      6'd42: r = 80'("@SKYWARN");
      6'd43: r = 80'("@CQ");
      6'd44: r = 80'("@HB");
      6'd45: r = 80'("@QSO");
      6'd46: r = 80'("@QSOPARTY");
      6'd47: r = 80'("@CONTEST");
      6'd48: r = 80'("@FIELDDAY");
      6'd49: r = 80'("@SOTA");
      6'd50: r = 80'("@IOTA");
      6'd51: r = 80'("@POTA");
      6'd52: r = 80'("@QRP");
      6'd53: r = 80'("@QRO");
      default: r = '0;
    endcase
    return r;
  endfunction

  // constant lookup: special name as a left-aligned text record
  function automatic text_t group_name(input logic [SidxW-1:0] idx);
    logic [8*NameMaxLen-1:0] raw;
    logic [LenW-1:0]         n;
    text_t                   t;
    int                      k;
    raw = name_raw(idx);
    n   = '0;
    t   = '0;
    for (int b = 0; b < NameMaxLen; b++) begin
      if (raw[8*b +: 8] != 8'h00) n = n + 4'd1;
    end
    for (int i = 0; i < NameMaxLen; i++) begin
      k = int'(n) - 1 - i;
      if (k >= 0) t.chars[i] = raw[8*k +: CharW];
    end
    t.len = n;
    return t;
  endfunction

endpackage

// File: hdl/cs28u_if.sv
// cs28u_if: valid/ready channel interfaces of the callsign unpack unit.
// cs28u_req_if carries packed callsigns in, cs28u_chr_if carries characters out.
// Depends on cs28u_pkg.
interface cs28u_req_if
  import cs28u_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CallW-1:0] packed_call;
  logic             portable_flag;

  modport source (output valid, output packed_call, output portable_flag, input ready);
  modport sink   (input valid, input packed_call, input portable_flag, output ready);
endinterface

interface cs28u_chr_if
  import cs28u_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: hdl/cs28u_front.sv
// cs28u_front: request intake, radix split pipeline and text assembly.
// Pushes one complete text record per request into the queue.
// Depends on cs28u_pkg and cs28u_if.
module cs28u_front
  import cs28u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cs28u_req_if.sink   req_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output text_t       q_data_o
);

  // pipeline valids
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic en;
  logic acc;

  // stage payloads
  logic [CallW-1:0] s0_p_q;
  logic [Q1W-1:0]   s1_p_q;
  logic [Q2W-1:0]   s2_p_q;
  logic [Q3W-1:0]   s3_p_q;
  logic [Q4W-1:0]   s4_p_q;
  logic             s0_flag_q, s0_spec_q;
  logic [SidxW-1:0] s0_sidx_q, s1_sidx_q, s2_sidx_q, s3_sidx_q, s4_sidx_q, s5_sidx_q;
  logic             s1_flag_q, s2_flag_q, s3_flag_q, s4_flag_q, s5_flag_q;
  logic             s1_spec_q, s2_spec_q, s3_spec_q, s4_spec_q, s5_spec_q;
  char_t            s1_c5_q, s2_c5_q, s3_c5_q, s4_c5_q, s5_c5_q;
  char_t            s2_c4_q, s3_c4_q, s4_c4_q, s5_c4_q;
  char_t            s3_c3_q, s4_c3_q, s5_c3_q;
  char_t            s4_c2_q, s5_c2_q;
  char_t            s5_c1_q, s5_c0_q;

  // per-stage quotients
  logic [CallW-1:0] q1, q2, q3, q4, q5;
  logic [CallW-1:0] r1, r2, r3, r4, r5;
  logic             in_spec;
  logic [SidxW-1:0] in_sidx;

  // whole pipeline moves unless the last stage is held by a full queue
  assign en          = !s5_v_q || !q_full_i;
  assign req_i.ready = en;
  assign acc         = req_i.valid && en;
  assign q_push_o    = s5_v_q && !q_full_i;

  // special name range check on the incoming value
  assign in_spec = (req_i.packed_call > CallW'(SpecialBase)) &&
                   (req_i.packed_call <= CallW'(SpecialBase + SpecialCount));
  assign in_sidx = SidxW'(req_i.packed_call - CallW'(SpecialBase + 1));

  // radix steps: quotient by reciprocal, remainder by shift-add
  always_comb begin
    q1 = div27(s0_p_q);
    r1 = s0_p_q - ((q1 << 4) + (q1 << 3) + (q1 << 1) + q1);
    q2 = div27(CallW'(s1_p_q));
    r2 = CallW'(s1_p_q) - ((q2 << 4) + (q2 << 3) + (q2 << 1) + q2);
    q3 = div27(CallW'(s2_p_q));
    r3 = CallW'(s2_p_q) - ((q3 << 4) + (q3 << 3) + (q3 << 1) + q3);
    q4 = div10(CallW'(s3_p_q));
    r4 = CallW'(s3_p_q) - ((q4 << 3) + (q4 << 1));
    q5 = div36(CallW'(s4_p_q));
    r5 = CallW'(s4_p_q) - ((q5 << 5) + (q5 << 2));
  end

  // control: stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= acc;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // payload: one symbol peeled off per radix stage, last symbol first; the last stage yields the first two
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_p_q    <= req_i.packed_call;
      s0_flag_q <= req_i.portable_flag;
      s0_spec_q <= in_spec;
      s0_sidx_q <= in_sidx;

      s1_p_q    <= Q1W'(q1);
      s1_c5_q   <= sym_char(SymW'(r1) + 6'd10);
      s1_flag_q <= s0_flag_q;
      s1_spec_q <= s0_spec_q;
      s1_sidx_q <= s0_sidx_q;

      s2_p_q    <= Q2W'(q2);
      s2_c4_q   <= sym_char(SymW'(r2) + 6'd10);
      s2_c5_q   <= s1_c5_q;
      s2_flag_q <= s1_flag_q;
      s2_spec_q <= s1_spec_q;
      s2_sidx_q <= s1_sidx_q;

      s3_p_q    <= Q3W'(q3);
      s3_c3_q   <= sym_char(SymW'(r3) + 6'd10);
      s3_c4_q   <= s2_c4_q;
      s3_c5_q   <= s2_c5_q;
      s3_flag_q <= s2_flag_q;
      s3_spec_q <= s2_spec_q;
      s3_sidx_q <= s2_sidx_q;

      s4_p_q    <= Q4W'(q4);
      s4_c2_q   <= sym_char(SymW'(r4));
      s4_c3_q   <= s3_c3_q;
      s4_c4_q   <= s3_c4_q;
      s4_c5_q   <= s3_c5_q;
      s4_flag_q <= s3_flag_q;
      s4_spec_q <= s3_spec_q;
      s4_sidx_q <= s3_sidx_q;

      // top quotient is at most 37 for any 28-bit value
      s5_c0_q   <= sym_char(SymW'(q5));
      s5_c1_q   <= sym_char(SymW'(r5));
      s5_c2_q   <= s4_c2_q;
      s5_c3_q   <= s4_c3_q;
      s5_c4_q   <= s4_c4_q;
      s5_c5_q   <= s4_c5_q;
      s5_flag_q <= s4_flag_q;
      s5_spec_q <= s4_spec_q;
      s5_sidx_q <= s4_sidx_q;
    end
  end

  // text assembly: prefix rewrite, trim, portable suffix or special name
  char_t           e [0:10];
  logic [LenW-1:0] el;
  logic            lead;
  logic [1:0]      trail;
  logic [LenW-1:0] m;
  logic [LenW-1:0] j;
  text_t           txt;

  always_comb begin
    for (int i = 0; i <= 10; i++) e[i] = ChSpace;
    if (s5_c0_q == Ch3 && s5_c1_q == ChD && s5_c2_q == Ch0) begin
      e[0] = Ch3;     e[1] = ChD;     e[2] = ChA;     e[3] = Ch0;
      e[4] = s5_c3_q; e[5] = s5_c4_q; e[6] = s5_c5_q;
      el   = 4'd7;
    end else if (s5_c0_q == ChQ && s5_c1_q >= ChA && s5_c1_q <= ChZ) begin
      e[0] = Ch3;     e[1] = ChX;     e[2] = s5_c1_q; e[3] = s5_c2_q;
      e[4] = s5_c3_q; e[5] = s5_c4_q; e[6] = s5_c5_q;
      el   = 4'd7;
    end else begin
      e[0] = s5_c0_q; e[1] = s5_c1_q; e[2] = s5_c2_q;
      e[3] = s5_c3_q; e[4] = s5_c4_q; e[5] = s5_c5_q;
      el   = 4'd6;
    end

    // only the first symbol can be a leading space; the digit stops trailing trim
    lead = (e[0] == ChSpace);
    if (s5_c5_q != ChSpace)      trail = 2'd0;
    else if (s5_c4_q != ChSpace) trail = 2'd1;
    else if (s5_c3_q != ChSpace) trail = 2'd2;
    else                         trail = 2'd3;
    m = el - {3'b0, lead} - {2'b0, trail};

    txt = '0;
    for (int i = 0; i < NameMaxLen; i++) begin
      j = LenW'(i) + {3'b0, lead};
      if (LenW'(i) < m) begin
        txt.chars[i] = e[j];
      end else if (s5_flag_q && LenW'(i) == m) begin
        txt.chars[i] = ChSlash;
      end else if (s5_flag_q && LenW'(i) == m + 4'd1) begin
        txt.chars[i] = ChP;
      end else begin
        txt.chars[i] = ChSpace;
      end
    end
    txt.len = m + (s5_flag_q ? 4'd2 : 4'd0);

    if (s5_spec_q) txt = group_name(s5_sidx_q);
  end

  assign q_data_o = txt;

endmodule

// File: hdl/cs28u_queue.sv
// cs28u_queue: small FIFO of text records between front and back.
// Head record is read combinationally. Depends on cs28u_pkg and the assert macros.
`include "callsign28_unpack_unit_assert.svh"
module cs28u_queue
  import cs28u_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  text_t push_data_i,
  input  logic  pop_i,
  output text_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  text_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `CU_NEVER(a_push_full, push_i && full_o, "queue pushed while full")
  `CU_NEVER(a_pop_empty, pop_i && empty_o, "queue popped while empty")
  `CU_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count beyond depth")

endmodule

// File: hdl/cs28u_back.sv
// cs28u_back: walks the head text record and drives one character per cycle while chr_o.ready is high.
// Output register decouples the character channel. Depends on cs28u_pkg,
// cs28u_if and the assert macros.
`include "callsign28_unpack_unit_assert.svh"
module cs28u_back
  import cs28u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  text_t       head_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  cs28u_chr_if.source chr_o
);

  logic            out_v_q;
  char_t           char_q;
  logic            last_q;
  logic [LenW-1:0] idx_q;
  logic            load;
  logic            take;
  logic            is_last;

  // refill the output register whenever it is empty or being drained
  assign load    = !out_v_q || chr_o.ready;
  assign take    = load && !q_empty_i;
  assign is_last = (idx_q == head_i.len - 4'd1);
  assign q_pop_o = take && is_last;

  assign chr_o.valid     = out_v_q;
  assign chr_o.char_code = char_q;
  assign chr_o.last_char = last_q;

  // control: output valid and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) out_v_q <= !q_empty_i;
      if (take) idx_q <= is_last ? '0 : idx_q + 4'd1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= head_i.chars[idx_q];
      last_q <= is_last;
    end
  end

  `CU_ASSERT(a_idx_range, !q_empty_i |-> (idx_q < head_i.len), "char index past record")
  `CU_ASSERT(a_idx_idle, q_empty_i |-> (idx_q == '0), "char index not reset at record end")

endmodule

// File: hdl/callsign28_unpack_unit.sv
// callsign28_unpack_unit: top level of the 28-bit callsign unpacker.
// Holds the front pipeline, the record queue and the character back end.
// Depends on cs28u_pkg, cs28u_if, cs28u_front, cs28u_queue, cs28u_back.
//
// Usage:
//   req_i (valid/ready) takes one packed_call with its portable_flag per request.
//   chr_o (valid/ready) returns the callsign text, one ASCII char_code per
//   transfer, with last_char set on the final character.
// Path: a taken request passes the intake register, five more pipeline
//   stages, one queue write and one output register before its first
//   character is valid.
// Throughput: one character per cycle at the output while chr_o.ready is high
//   and a record is queued; a request yields 2 to 10 characters. The front
//   takes a new request every cycle while the queue has room, so requests
//   overlap with the characters of earlier ones.
// Reset: pipeline valids, queue and output register are cleared; no request
//   is in flight and chr_o.valid is low.
// Stall: when chr_o.ready is low the current character holds; the queue
//   fills, then the front pipeline holds and req_i.ready drops.
module callsign28_unpack_unit
  import cs28u_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cs28u_req_if.sink   req_i,
  cs28u_chr_if.source chr_o
);

  logic  q_push, q_pop, q_full, q_empty;
  text_t q_wdata, q_head;

  // intake and decode
  cs28u_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // decoupling queue
  cs28u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // character serializer
  cs28u_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .chr_o     (chr_o)
  );

endmodule
